>>> hw/rtl/spirv_integer_alu_fold_macros.svh
// Assertion macros used by the port checker of the integer ALU.
// Depends on nothing; taken in by `include.
`ifndef SPIRV_INTEGER_ALU_FOLD_MACROS_SVH
`define SPIRV_INTEGER_ALU_FOLD_MACROS_SVH

// Overlapping implication, checked outside reset.
`define SAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle, outside reset.
`define SAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/saf_pkg.sv
// Package of the integer ALU: operation codes, field widths and the control
// record that travels down the pipeline. Depends on nothing.
package saf_pkg;

    localparam int FIELD_W = 64;
    localparam int MODE_W  = 5;
    localparam int RWID_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_SNEGATE = 5'd0,  OP_SDIV   = 5'd1,  OP_SREM   = 5'd2,  OP_SMOD  = 5'd3,
        OP_SRA     = 5'd4,  OP_SLT    = 5'd5,  OP_SGT    = 5'd6,  OP_SLE   = 5'd7,
        OP_SGE     = 5'd8,  OP_ADD    = 5'd9,  OP_SUB    = 5'd10, OP_MUL   = 5'd11,
        OP_UDIV    = 5'd12, OP_UMOD   = 5'd13, OP_SRL    = 5'd14, OP_SLL   = 5'd15,
        OP_OR      = 5'd16, OP_XOR    = 5'd17, OP_AND    = 5'd18, OP_NOT   = 5'd19,
        OP_LOR     = 5'd20, OP_LAND   = 5'd21, OP_LNOT   = 5'd22, OP_EQ    = 5'd23,
        OP_NE      = 5'd24, OP_ULT    = 5'd25, OP_UGT    = 5'd26, OP_ULE   = 5'd27,
        OP_UGE     = 5'd28, OP_SELECT = 5'd29, OP_CONVERT = 5'd30, OP_UNSUP = 5'd31
    } op_t;

    typedef struct packed {
        logic              valid;
        op_t               mode;
        logic [RWID_W-1:0] width;
        logic              neg_q;
        logic              neg_r;
        logic              b_neg;
        logic              dz;
    } ctl_t;

endpackage

>>> hw/rtl/saf_req_if.sv
// Request channel of the integer ALU: valid/ready handshake and operands.
// Depends on saf_pkg.
interface saf_req_if;
    import saf_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [FIELD_W-1:0]  operand_a;
    logic [FIELD_W-1:0]  operand_b;
    logic [FIELD_W-1:0]  operand_c;
    logic [RWID_W-1:0]   result_width;

    modport source (output valid, mode, operand_a, operand_b, operand_c, result_width,
                    input ready);
    modport sink   (input valid, mode, operand_a, operand_b, operand_c, result_width,
                    output ready);
endinterface

>>> hw/rtl/saf_rsp_if.sv
// Response channel of the integer ALU: valid/ready handshake and result.
// Depends on saf_pkg.
interface saf_rsp_if;
    import saf_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result;
    logic               unsupported;

    modport source (output valid, result, unsupported, input ready);
    modport sink   (input valid, result, unsupported, output ready);
endinterface

>>> hw/rtl/saf_pre.sv
// Front stage of the integer ALU: decodes a request, works out every operation
// but the divisions and the multiplication, and prepares the divider and multiplier cells.
// Depends on saf_pkg.
module saf_pre
    import saf_pkg::*;
#(
    parameter int W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               req_valid,
    input  logic [MODE_W-1:0]  req_mode,
    input  logic [FIELD_W-1:0] req_a,
    input  logic [FIELD_W-1:0] req_b,
    input  logic [FIELD_W-1:0] req_c,
    input  logic [RWID_W-1:0]  req_width,
    output ctl_t               ctl,
    output logic [W-1:0]       aux,
    output logic [W-1:0]       n,
    output logic [W-1:0]       d,
    output logic [W-1:0]       mcand,
    output logic [W-1:0]       mplier
);
    localparam int SW = $clog2(W);

    ctl_t         ctl_reg, ctl_next;
    logic [W-1:0] aux_reg, aux_next, n_reg, n_next, d_reg, d_next;
    logic [W-1:0] mcand_reg, mplier_reg;
    logic [W-1:0] ua, ub, uc;
    logic         a_neg, b_neg, big;
    logic [SW-1:0] amt;
    op_t          op;

    assign ua    = req_a[W-1:0];
    assign ub    = req_b[W-1:0];
    assign uc    = req_c[W-1:0];
    assign a_neg = ua[W-1];
    assign b_neg = ub[W-1];
    assign big   = {1'b0, ub} >= (W+1)'(W);
    assign amt   = ub[SW-1:0];
    assign op    = op_t'(req_mode);

    always_comb
    begin
        ctl_next.valid = req_valid;
        ctl_next.mode  = op;
        ctl_next.width = req_width;
        ctl_next.neg_q = 1'b0;
        ctl_next.neg_r = 1'b0;
        ctl_next.b_neg = b_neg;
        ctl_next.dz    = (ub == '0);
        n_next         = ua;
        d_next         = ub;
        aux_next       = '0;
        if (op == OP_SDIV || op == OP_SREM || op == OP_SMOD)
        begin
            n_next         = a_neg ? (W'(0) - ua) : ua;
            d_next         = b_neg ? (W'(0) - ub) : ub;
            ctl_next.neg_q = a_neg ^ b_neg;
            ctl_next.neg_r = a_neg;
        end
        case (op)
            OP_SNEGATE: aux_next = W'(0) - ua;
            OP_SDIV, OP_SREM, OP_SMOD: aux_next = ub;
            OP_SRA:     aux_next = big ? {W{a_neg}} : W'($signed(ua) >>> amt);
            OP_SLT:     aux_next = W'($signed(ua) < $signed(ub));
            OP_SGT:     aux_next = W'($signed(ua) > $signed(ub));
            OP_SLE:     aux_next = W'($signed(ua) <= $signed(ub));
            OP_SGE:     aux_next = W'($signed(ua) >= $signed(ub));
            OP_ADD:     aux_next = ua + ub;
            OP_SUB:     aux_next = ua - ub;
            OP_SRL:     aux_next = big ? '0 : (ua >> amt);
            OP_SLL:     aux_next = big ? '0 : (ua << amt);
            OP_OR:      aux_next = ua | ub;
            OP_XOR:     aux_next = ua ^ ub;
            OP_AND:     aux_next = ua & ub;
            OP_NOT:     aux_next = ~ua;
            OP_LOR:     aux_next = W'((ua != '0) || (ub != '0));
            OP_LAND:    aux_next = W'((ua != '0) && (ub != '0));
            OP_LNOT:    aux_next = W'(ua == '0);
            OP_EQ:      aux_next = W'(ua == ub);
            OP_NE:      aux_next = W'(ua != ub);
            OP_ULT:     aux_next = W'(ua < ub);
            OP_UGT:     aux_next = W'(ua > ub);
            OP_ULE:     aux_next = W'(ua <= ub);
            OP_UGE:     aux_next = W'(ua >= ub);
            OP_SELECT:  aux_next = (ua != '0) ? ub : uc;
            OP_CONVERT: aux_next = ua;
            default:    aux_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aux_reg       <= aux_next;
            n_reg         <= n_next;
            d_reg         <= d_next;
            mcand_reg     <= ua;
            mplier_reg    <= ub;
        end
    end

    assign ctl    = ctl_reg;
    assign aux    = aux_reg;
    assign n      = n_reg;
    assign d      = d_reg;
    assign mcand  = mcand_reg;
    assign mplier = mplier_reg;
endmodule

>>> hw/rtl/saf_cell.sv
// One cell of the divider and multiplier chain: a restoring division step
// and a shift-and-add multiply step, registered. Depends on saf_pkg.
module saf_cell
    import saf_pkg::*;
#(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  ctl_t         src_ctl,
    input  logic [W-1:0] src_aux,
    input  logic [W-1:0] src_n,
    input  logic [W-1:0] src_rem,
    input  logic [W-1:0] src_d,
    input  logic [W-1:0] src_mcand,
    input  logic [W-1:0] src_mplier,
    input  logic [W-1:0] src_prod,
    output ctl_t         dst_ctl,
    output logic [W-1:0] dst_aux,
    output logic [W-1:0] dst_n,
    output logic [W-1:0] dst_rem,
    output logic [W-1:0] dst_d,
    output logic [W-1:0] dst_mcand,
    output logic [W-1:0] dst_mplier,
    output logic [W-1:0] dst_prod
);
    ctl_t         ctl_reg;
    logic [W-1:0] aux_reg, n_reg, rem_reg, d_reg, mcand_reg, mplier_reg, prod_reg;
    logic [W-1:0] n_next, rem_next, prod_next;
    logic [W:0]   shifted, trial;

    // The dividend bits leave at the top of n while quotient bits enter below.
    always_comb
    begin
        shifted  = {src_rem, src_n[W-1]};
        trial    = shifted - {1'b0, src_d};
        if (!trial[W])
        begin
            rem_next = trial[W-1:0];
            n_next   = {src_n[W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[W-1:0];
            n_next   = {src_n[W-2:0], 1'b0};
        end
        prod_next = src_prod + (src_mplier[0] ? src_mcand : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= src_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aux_reg       <= src_aux;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
            d_reg         <= src_d;
            mcand_reg     <= {src_mcand[W-2:0], 1'b0};
            mplier_reg    <= {1'b0, src_mplier[W-1:1]};
            prod_reg      <= prod_next;
        end
    end

    assign dst_ctl    = ctl_reg;
    assign dst_aux    = aux_reg;
    assign dst_n      = n_reg;
    assign dst_rem    = rem_reg;
    assign dst_d      = d_reg;
    assign dst_mcand  = mcand_reg;
    assign dst_mplier = mplier_reg;
    assign dst_prod   = prod_reg;
endmodule

>>> hw/rtl/saf_post.sv
// Output stage of the integer ALU: sign fix-up of quotient and remainder,
// result selection, width mask and the output register. Depends on saf_pkg.
module saf_post
    import saf_pkg::*;
#(
    parameter int W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  ctl_t               ctl,
    input  logic [W-1:0]       aux,
    input  logic [W-1:0]       q,
    input  logic [W-1:0]       r,
    input  logic [W-1:0]       prod,
    output logic               valid,
    output logic [FIELD_W-1:0] result,
    output logic               unsupported
);
    logic               valid_reg;
    logic [FIELD_W-1:0] result_reg, result_next;
    logic               unsup_reg, unsup_next;
    logic [W-1:0]       res, mask;
    logic               adj;

    always_comb
    begin
        // A nonzero remainder whose sign differs from the divisor's is moved
        // by one divisor; aux holds the divisor for the division requests.
        adj = (r != '0) && (ctl.neg_r != ctl.b_neg);
        case (ctl.mode)
            OP_SDIV: res = ctl.dz ? '0 : (ctl.neg_q ? (W'(0) - q) : q);
            OP_SREM: res = ctl.dz ? '0 : (ctl.neg_r ? (W'(0) - r) : r);
            OP_SMOD:
            begin
                if (ctl.dz)
                    res = '0;
                else if (ctl.neg_r)
                    res = adj ? (aux - r) : (W'(0) - r);
                else
                    res = adj ? (r + aux) : r;
            end
            OP_UDIV: res = ctl.dz ? '0 : q;
            OP_UMOD: res = ctl.dz ? '0 : r;
            OP_MUL:  res = prod;
            default: res = aux;
        endcase
        if (ctl.width >= RWID_W'(W))
            mask = '1;
        else
            mask = (W'(1) << ctl.width) - W'(1);
        result_next = FIELD_W'(res & mask);
        unsup_next  = (ctl.mode == OP_UNSUP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            unsup_reg  <= unsup_next;
        end
    end

    assign valid       = valid_reg;
    assign result      = result_reg;
    assign unsupported = unsup_reg;
endmodule

>>> hw/rtl/spirv_integer_alu_fold.sv
// Integer ALU for one scalar request, top level.
// Request channel req: mode, operand_a/b/c and result_width; the operands
// arrive already extended to 64 bits. Response channel rsp: result, masked
// to result_width, and the unsupported flag for the undefined code.
// From acceptance to rsp.valid a request passes one decode stage, one
// divider and multiplier cell per data bit, and the output register. A
// request may enter every cycle while the receiver does not stall; the cell
// chain allows that, as each cell takes one quotient bit and one multiplier
// bit. Division by zero gives 0, shifts of the data width or more saturate,
// and signed modulo takes the sign of the divisor.
// Reset clears every valid flag in the chain, that of the output included.
// When the receiver stalls with a response waiting, the whole chain holds
// and req.ready falls; while the output register is empty or being taken,
// req.ready is high.
// Depends on saf_pkg, saf_req_if, saf_rsp_if, saf_pre, saf_cell, saf_post.
module spirv_integer_alu_fold
    import saf_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    saf_req_if.sink  req,
    saf_rsp_if.source rsp
);
    localparam int W = DATA_WIDTH;

    logic         en;
    ctl_t         ctl_s    [W+1];
    logic [W-1:0] aux_s    [W+1];
    logic [W-1:0] n_s      [W+1];
    logic [W-1:0] rem_s    [W+1];
    logic [W-1:0] d_s      [W+1];
    logic [W-1:0] mcand_s  [W+1];
    logic [W-1:0] mplier_s [W+1];
    logic [W-1:0] prod_s   [W+1];

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;
    assign rem_s[0]  = '0;
    assign prod_s[0] = '0;

    saf_pre #(.W(W)) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_a     (req.operand_a),
        .req_b     (req.operand_b),
        .req_c     (req.operand_c),
        .req_width (req.result_width),
        .ctl       (ctl_s[0]),
        .aux       (aux_s[0]),
        .n         (n_s[0]),
        .d         (d_s[0]),
        .mcand     (mcand_s[0]),
        .mplier    (mplier_s[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        saf_cell #(.W(W)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .src_ctl    (ctl_s[i]),
            .src_aux    (aux_s[i]),
            .src_n      (n_s[i]),
            .src_rem    (rem_s[i]),
            .src_d      (d_s[i]),
            .src_mcand  (mcand_s[i]),
            .src_mplier (mplier_s[i]),
            .src_prod   (prod_s[i]),
            .dst_ctl    (ctl_s[i+1]),
            .dst_aux    (aux_s[i+1]),
            .dst_n      (n_s[i+1]),
            .dst_rem    (rem_s[i+1]),
            .dst_d      (d_s[i+1]),
            .dst_mcand  (mcand_s[i+1]),
            .dst_mplier (mplier_s[i+1]),
            .dst_prod   (prod_s[i+1])
        );
    end

    saf_post #(.W(W)) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctl         (ctl_s[W]),
        .aux         (aux_s[W]),
        .q           (n_s[W]),
        .r           (rem_s[W]),
        .prod        (prod_s[W]),
        .valid       (rsp.valid),
        .result      (rsp.result),
        .unsupported (rsp.unsupported)
    );
endmodule

>>> hw/rtl/saf_check.sv
// Port-level checks of the integer ALU, bound to the top level.
// Depends on saf_pkg and spirv_integer_alu_fold_macros.svh.
`include "spirv_integer_alu_fold_macros.svh"

module saf_check
    import saf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] out_result,
    input logic               out_unsupported
);
    // A pending response that is not taken must stay offered.
    `SAF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // With the output register free the block must take a request.
    `SAF_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid || out_ready, in_ready)
    // The undefined code always yields a zero result.
    `SAF_ASSERT_IMP(a_unsup_zero, clk, rst_n, out_valid && out_unsupported,
                    out_result == '0)
    // A stalled response keeps its result.
    `SAF_ASSERT_NXT(a_result_hold, clk, rst_n, out_valid && !out_ready,
                    $stable(out_result))
endmodule

bind spirv_integer_alu_fold saf_check u_saf_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (req.ready),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_result      (rsp.result),
    .out_unsupported (rsp.unsupported)
);

>>> tb/tb.sv
// Self-checking testbench for the integer ALU: random and directed requests,
// each result compared with a behavioural prediction.
// Depends on saf_pkg, saf_req_if, saf_rsp_if and spirv_integer_alu_fold.
`timescale 1ns / 100ps

module tb;
    import saf_pkg::*;

    localparam int LATENCY = 66;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;

    typedef struct {
        op_t         mode;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [6:0]  width;
    } alu_req_t;

    typedef struct {
        logic [63:0] result;
        logic        unsupported;
    } alu_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    saf_req_if req ();
    saf_rsp_if rsp ();

    spirv_integer_alu_fold uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #2 clk = ~clk;

    alu_req_t pending_reqs[$];
    alu_rsp_t expected_rsps[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  stim_done = 1'b0;
    bit  hold_off_req = 1'b0;
    bit  drain_pause = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_count = 0;

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] signed_rem(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        if (b == '0)
            return '0;
        r = mag(a) % mag(b);
        return a[63] ? -r : r;
    endfunction

    function automatic alu_rsp_t alu_predict(alu_req_t r);
        alu_rsp_t    o;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] res;
        logic [63:0] q;
        int          w;
        bit          big;
        a = r.a;
        b = r.b;
        res = '0;
        o.unsupported = 1'b0;
        big = b >= 64'd64;
        w = (r.width > 7'd64) ? 64 : int'(r.width);
        case (r.mode)
            OP_SNEGATE: res = -a;
            OP_SDIV:
            begin
                if (b != '0)
                begin
                    q = mag(a) / mag(b);
                    res = (a[63] != b[63]) ? -q : q;
                end
            end
            OP_SREM:    res = signed_rem(a, b);
            OP_SMOD:
            begin
                res = signed_rem(a, b);
                if (res != '0 && res[63] != b[63])
                    res = res + b;
            end
            OP_SRA:     res = big ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
            OP_SLT:     res = 64'((a ^ TOP) < (b ^ TOP));
            OP_SGT:     res = 64'((b ^ TOP) < (a ^ TOP));
            OP_SLE:     res = 64'(!((b ^ TOP) < (a ^ TOP)));
            OP_SGE:     res = 64'(!((a ^ TOP) < (b ^ TOP)));
            OP_ADD:     res = a + b;
            OP_SUB:     res = a - b;
            OP_MUL:     res = a * b;
            OP_UDIV:    res = (b != '0) ? a / b : '0;
            OP_UMOD:    res = (b != '0) ? a % b : '0;
            OP_SRL:     res = big ? '0 : a >> b[5:0];
            OP_SLL:     res = big ? '0 : a << b[5:0];
            OP_OR:      res = a | b;
            OP_XOR:     res = a ^ b;
            OP_AND:     res = a & b;
            OP_NOT:     res = ~a;
            OP_LOR:     res = 64'(a != '0 || b != '0);
            OP_LAND:    res = 64'(a != '0 && b != '0);
            OP_LNOT:    res = 64'(a == '0);
            OP_EQ:      res = 64'(a == b);
            OP_NE:      res = 64'(a != b);
            OP_ULT:     res = 64'(a < b);
            OP_UGT:     res = 64'(a > b);
            OP_ULE:     res = 64'(a <= b);
            OP_UGE:     res = 64'(a >= b);
            OP_SELECT:  res = (a != '0) ? b : r.c;
            OP_CONVERT: res = a;
            default:
            begin
                res = '0;
                o.unsupported = 1'b1;
            end
        endcase
        o.result = (w >= 64) ? res : res & ((64'd1 << w) - 64'd1);
        return o;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 70));
            1: v = -64'($urandom_range(1, 70));
            2: v = TOP;
            3: v = 64'($signed(v[31:0]));
            default: ;
        endcase
        return v;
    endfunction

    function automatic int short_or_long_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic queue_req(op_t m, logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [6:0] w);
        alu_req_t r;
        r.mode = m;
        r.a = a;
        r.b = b;
        r.c = c;
        r.width = w;
        pending_reqs.push_back(r);
    endtask

    // Request driver: a due request is loaded on the edge that accepts the old one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
            req.operand_c <= '0;
            req.result_width <= '0;
            send_gap <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                expected_rsps.push_back(alu_predict('{op_t'(req.mode), req.operand_a,
                    req.operand_b, req.operand_c, req.result_width}));
            if (send_gap > 0 || drain_pause || pending_reqs.size() == 0)
            begin
                req.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                alu_req_t r;
                r = pending_reqs.pop_front();
                req.valid <= 1'b1;
                req.mode <= r.mode;
                req.operand_a <= r.a;
                req.operand_b <= r.b;
                req.operand_c <= r.c;
                req.result_width <= r.width;
                send_gap <= hold_off_req ? 0 : short_or_long_gap();
            end
        end
    end

    // Response monitor and receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
            hold_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response: result %h", rsp.result);
                    errors++;
                end
                else
                begin
                    alu_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp.result !== e.result)
                    begin
                        $error("result: expected %h, actual %h", e.result, rsp.result);
                        errors++;
                    end
                    if (rsp.unsupported !== e.unsupported)
                    begin
                        $error("unsupported: expected %b, actual %b", e.unsupported,
                               rsp.unsupported);
                        errors++;
                    end
                end
            end
            if (hold_off_req && hold_count < 300)
            begin
                rsp.ready <= 1'b0;
                hold_count <= hold_count + 1;
            end
            else if (recv_gap > 0)
            begin
                rsp.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
                recv_gap <= short_or_long_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] ext[6];
        ext = '{64'd0, 64'd1, '1, TOP, 64'h7fff_ffff_ffff_ffff, 64'd64};
        // Directed: every operation at full width, plus the corner cases.
        for (int m = 0; m < 32; m++)
            queue_req(op_t'(m), ext[m % 6], ext[(m + 2) % 6], '1, 7'd64);
        queue_req(OP_SDIV, TOP, '1, 0, 7'd64);
        queue_req(OP_SREM, TOP, '1, 0, 7'd8);
        queue_req(OP_SMOD, TOP, '1, 0, 7'd1);
        queue_req(OP_SMOD, -64'd7, 64'd3, 0, 7'd64);
        queue_req(OP_SMOD, 64'd7, -64'd3, 0, 7'd64);
        queue_req(OP_UDIV, '1, 0, 0, 7'd64);
        queue_req(OP_SRA, TOP, 64'd64, 0, 7'd64);
        queue_req(OP_SLL, '1, 64'd63, 0, 7'd64);
        queue_req(OP_CONVERT, '1, 0, 0, 7'd0);
        queue_req(OP_CONVERT, '1, 0, 0, 7'd127);
        queue_req(OP_SELECT, 0, 64'd5, 64'd9, 7'd64);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 900; i++)
        begin
            int w;
            w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                : ($urandom_range(0, 1) ? 64 : $urandom_range(1, 64));
            queue_req(op_t'($urandom_range(0, 31)), rand_operand(), rand_operand(),
                      rand_operand(), 7'(w));
            if (i == 300)
            begin
                // Long receiver hold-off while requests keep coming.
                while (pending_reqs.size() > 0)
                    @(posedge clk);
                hold_off_req = 1'b1;
                for (int k = 0; k < 200; k++)
                    queue_req(op_t'($urandom_range(0, 31)), rand_operand(),
                              rand_operand(), rand_operand(), 7'd64);
                while (hold_count < 300)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (i == 700)
            begin
                while (pending_reqs.size() > 0)
                    @(posedge clk);
                drain_pause = 1'b1;
                @(posedge clk);
                while (expected_rsps.size() > 0 || req.valid)
                    @(posedge clk);
                drain_pause = 1'b0;
            end
        end
        while (pending_reqs.size() > 0 || req.valid)
            @(posedge clk);
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
